// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the list update unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the clock after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Consequent that must hold in the same clock as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/uplru_pkg.sv =====
// Constants, state type and control structs of the list update unit.
`timescale 1ns / 1ps

package uplru_pkg;

	localparam int CAPACITY = 4096;
	localparam int OWNERS   = 8;
	localparam int KEY_STEP = 'h1000;

	localparam int OWNER_W = (OWNERS > 1) ? $clog2(OWNERS) : 1;
	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int ADDR_W  = $clog2(OWNERS * CAPACITY);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_INS_KEY,
		ST_INS_SCAN,
		ST_INS_NEXT,
		ST_REM_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_clear;
		logic rd_issue;
		logic append;
		logic key_next;
		logic keep;
		logic drop;
		logic compact_end;
		logic set_blocked;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic owner_ok;
		logic range_empty;
		logic op_remove;
		logic full;
		logic rd_end;
		logic pend;
		logic hit;
		logic drop_ok;
		logic last_key;
	} status_t;

endpackage

// ===== rtl/core/uplru_ctrl.sv =====
// Sequencer of the list update unit: walks keys and list entries.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uplru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  uplru_pkg::status_t  status,
	output uplru_pkg::cmd_t     cmd
);

	uplru_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uplru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			uplru_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = uplru_pkg::ST_DECIDE;
				end
			end
			uplru_pkg::ST_DECIDE: begin
				if (!status.owner_ok || status.range_empty) begin
					state_d = uplru_pkg::ST_DONE;
				end else if (status.op_remove) begin
					if (status.full) begin
						cmd.set_blocked = 1'b1;
						state_d         = uplru_pkg::ST_DONE;
					end else begin
						cmd.scan_clear = 1'b1;
						state_d        = uplru_pkg::ST_REM_SCAN;
					end
				end else begin
					state_d = uplru_pkg::ST_INS_KEY;
				end
			end
			uplru_pkg::ST_INS_KEY: begin
				if (status.full) begin
					cmd.set_blocked = 1'b1;
					state_d         = uplru_pkg::ST_DONE;
				end else begin
					cmd.scan_clear = 1'b1;
					state_d        = uplru_pkg::ST_INS_SCAN;
				end
			end
			uplru_pkg::ST_INS_SCAN: begin
				if (status.hit) begin
					state_d = uplru_pkg::ST_INS_NEXT;
				end else if (status.rd_end && !status.pend) begin
					// no match anywhere in the list: append the pair
					cmd.append = 1'b1;
					state_d    = uplru_pkg::ST_INS_NEXT;
				end else if (!status.rd_end) begin
					cmd.rd_issue = 1'b1;
				end
			end
			uplru_pkg::ST_INS_NEXT: begin
				if (status.last_key) begin
					state_d = uplru_pkg::ST_DONE;
				end else begin
					cmd.key_next = 1'b1;
					state_d      = uplru_pkg::ST_INS_KEY;
				end
			end
			uplru_pkg::ST_REM_SCAN: begin
				if (status.pend) begin
					cmd.drop = status.drop_ok;
					cmd.keep = !status.drop_ok;
				end
				if (!status.rd_end) begin
					cmd.rd_issue = 1'b1;
				end else if (!status.pend) begin
					cmd.compact_end = 1'b1;
					state_d         = uplru_pkg::ST_DONE;
				end
			end
			uplru_pkg::ST_DONE: begin
				done       = 1'b1;
				cmd.commit = 1'b1;
				state_d    = uplru_pkg::ST_IDLE;
			end
			default: begin
				state_d = uplru_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_done_to_idle, clk, arst_n, state_q == uplru_pkg::ST_DONE, state_q == uplru_pkg::ST_IDLE, "result beat not followed by idle")
	`ASSERT_NEXT(a_accept_decide, clk, arst_n, start && !busy, state_q == uplru_pkg::ST_DECIDE, "accepted command did not reach decision")

endmodule

// ===== rtl/core/uplru_datapath.sv =====
// Datapath of the list update unit: pair memory, counts and compare logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uplru_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                local_owner_we,
	input  logic [2:0]          local_owner,
	input  logic                operation,
	input  logic [2:0]          owner,
	input  logic signed [31:0]  pair_value,
	input  logic signed [31:0]  start_key,
	input  logic signed [31:0]  end_key,
	input  uplru_pkg::cmd_t     cmd,
	output uplru_pkg::status_t  status,
	output logic [12:0]         added,
	output logic [12:0]         removed,
	output logic [12:0]         list_count,
	output logic [15:0]         local_count,
	output logic                blocked_full
);

	localparam int CNT_W   = uplru_pkg::CNT_W;
	localparam int IDX_W   = uplru_pkg::IDX_W;
	localparam int ADDR_W  = uplru_pkg::ADDR_W;
	localparam int OWNER_W = uplru_pkg::OWNER_W;

	logic [63:0] mem [uplru_pkg::OWNERS * uplru_pkg::CAPACITY];
	logic [63:0] rdata_q;

	logic [CNT_W-1:0] count_q [uplru_pkg::OWNERS];

	logic               op_q;
	logic [2:0]         owner_q;
	logic [31:0]        pv_q;
	logic signed [31:0] s_q;
	logic signed [31:0] e_q;
	logic signed [32:0] key_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   wr_idx_q;
	logic [CNT_W-1:0]   added_q;
	logic [CNT_W-1:0]   removed_q;
	logic               blocked_q;
	logic               pend_q;
	logic [15:0]        local_q;
	logic [2:0]         local_owner_q;

	logic               owner_ok;
	logic               in_owner_ok;
	logic [OWNER_W-1:0] owner_idx;
	logic [OWNER_W-1:0] in_owner_idx;
	logic               is_local;
	logic signed [32:0] next_key;
	logic [31:0]        rd_key;
	logic [31:0]        rd_val;
	logic signed [31:0] rd_key_s;
	logic               key_match;
	logic               range_match;
	logic [ADDR_W-1:0]  list_base;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [63:0]        wr_data;
	logic               wr_en;

	assign owner_ok     = 32'(owner_q) < uplru_pkg::OWNERS;
	assign in_owner_ok  = 32'(owner) < uplru_pkg::OWNERS;
	assign owner_idx    = OWNER_W'(owner_q);
	assign in_owner_idx = OWNER_W'(owner);
	assign is_local     = owner_q == local_owner_q;
	assign next_key     = key_q + 33'(uplru_pkg::KEY_STEP);

	assign rd_key   = rdata_q[63:32];
	assign rd_val   = rdata_q[31:0];
	assign rd_key_s = signed'(rd_key);

	assign key_match   = (rd_key == key_q[31:0]) && (rd_val == pv_q);
	// remove takes keys on the stepping grid of the range only
	assign range_match = (rd_val == pv_q) && (rd_key_s >= s_q) && (rd_key_s <= e_q)
		&& (((rd_key - 32'(s_q)) & 32'(uplru_pkg::KEY_STEP - 1)) == 32'd0);

	assign list_base = ADDR_W'(ADDR_W'(owner_idx) * ADDR_W'(uplru_pkg::CAPACITY));
	assign rd_addr   = ADDR_W'(list_base + ADDR_W'(rd_idx_q[IDX_W-1:0]));
	assign wr_en     = cmd.append || cmd.keep;
	assign wr_addr   = cmd.append ? ADDR_W'(list_base + ADDR_W'(cnt_q[IDX_W-1:0]))
	                              : ADDR_W'(list_base + ADDR_W'(wr_idx_q[IDX_W-1:0]));
	assign wr_data   = cmd.append ? {key_q[31:0], pv_q} : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			owner_q <= owner;
			pv_q    <= pair_value;
			s_q     <= start_key;
			e_q     <= end_key;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= 33'(start_key);
		end else if (cmd.key_next) begin
			key_q <= next_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_owner_q <= '0;
		end else if (local_owner_we) begin
			local_owner_q <= local_owner;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < uplru_pkg::OWNERS; i++) begin
				count_q[i] <= '0;
			end
		end else if (cmd.commit && owner_ok) begin
			count_q[owner_idx] <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			added_q   <= '0;
			removed_q <= '0;
			blocked_q <= 1'b0;
			pend_q    <= 1'b0;
			local_q   <= '0;
		end else begin
			pend_q <= cmd.rd_issue;
			if (cmd.load) begin
				cnt_q     <= in_owner_ok ? count_q[in_owner_idx] : '0;
				added_q   <= '0;
				removed_q <= '0;
				blocked_q <= 1'b0;
			end
			if (cmd.scan_clear) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
			end
			if (cmd.rd_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (cmd.append) begin
				cnt_q   <= cnt_q + CNT_W'(1);
				added_q <= added_q + CNT_W'(1);
				if (is_local) begin
					local_q <= local_q + 16'd1;
				end
			end
			if (cmd.keep) begin
				wr_idx_q <= wr_idx_q + CNT_W'(1);
			end
			if (cmd.drop) begin
				removed_q <= removed_q + CNT_W'(1);
				if (is_local) begin
					local_q <= local_q - 16'd1;
				end
			end
			if (cmd.compact_end) begin
				cnt_q <= wr_idx_q;
			end
			if (cmd.set_blocked) begin
				blocked_q <= 1'b1;
			end
		end
	end

	always_comb begin
		status.owner_ok    = owner_ok;
		status.range_empty = s_q > e_q;
		status.op_remove   = op_q == uplru_pkg::OP_REMOVE;
		status.full        = cnt_q == CNT_W'(uplru_pkg::CAPACITY);
		status.rd_end      = rd_idx_q == cnt_q;
		status.pend        = pend_q;
		status.hit         = pend_q && key_match;
		status.drop_ok     = range_match;
		status.last_key    = next_key > 33'(e_q);
	end

	assign added        = 13'(added_q);
	assign removed      = 13'(removed_q);
	assign list_count   = owner_ok ? 13'(cnt_q) : 13'd0;
	assign local_count  = local_q;
	assign blocked_full = blocked_q;

	`ASSERT_ALWAYS(a_cnt_cap, clk, arst_n, cnt_q <= CNT_W'(uplru_pkg::CAPACITY), "list count above capacity")
	`ASSERT_ALWAYS(a_wr_behind, clk, arst_n, wr_idx_q <= rd_idx_q, "compaction write passed read")
	`ASSERT_SAME(a_append_room, clk, arst_n, cmd.append, cnt_q != CNT_W'(uplru_pkg::CAPACITY), "append into full list")

endmodule

// ===== rtl/core/unique_pair_list_range_update_unit.sv =====
// Top level of the unique pair list range update unit.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; busy then stays high until
// the result beat, which appears on the result ports for exactly one cycle with done
// high and cannot be held off, so it must be captured in that cycle. The pair memory
// has one read and one write port and the sequencer reads one list entry per cycle.
// An insert takes each key of the range in turn and scans the list for it, appending
// the pair when no entry matches; a scan stops early on a match, and the insert stops
// when the list fills. A remove scans the list once and compacts away the entries it
// drops. An empty range or a full list on remove goes straight to the result beat.
// The local owner register may be written at any time the unit is idle.
module unique_pair_list_range_update_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               local_owner_we,
	input  logic [2:0]         local_owner,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [2:0]         owner,
	input  logic signed [31:0] pair_value,
	input  logic signed [31:0] start_key,
	input  logic signed [31:0] end_key,
	output logic               done,
	output logic [12:0]        added,
	output logic [12:0]        removed,
	output logic [12:0]        list_count,
	output logic [15:0]        local_count,
	output logic               blocked_full
);

	uplru_pkg::cmd_t    cmd;
	uplru_pkg::status_t status;

	uplru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.status (status),
		.cmd    (cmd)
	);

	uplru_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.local_owner_we (local_owner_we),
		.local_owner    (local_owner),
		.operation      (operation),
		.owner          (owner),
		.pair_value     (pair_value),
		.start_key      (start_key),
		.end_key        (end_key),
		.cmd            (cmd),
		.status         (status),
		.added          (added),
		.removed        (removed),
		.list_count     (list_count),
		.local_count    (local_count),
		.blocked_full   (blocked_full)
	);

endmodule
